// ----- hw/rtl/otps_pkg.sv -----
// Package for the one-wire temperature poll sequencer.
// Holds field widths, bus command and one-wire byte codes, step codes and shared structs.
// No dependencies; every other file of the block imports it.
`default_nettype none

package otps_pkg;

	// Field widths.
	localparam int unsigned CMD_W     = 2;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned TEMP_W    = 16;
	localparam int unsigned COUNT_W   = 16;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_POLL_PERIOD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONV_WAIT   = 1'd1;

	// Configuration reset values, in milliseconds.
	localparam logic [CFG_W-1:0] POLL_PERIOD_RST = 16'd3000;
	localparam logic [CFG_W-1:0] CONV_WAIT_RST   = 16'd800;

	// One-wire function bytes.
	localparam logic [BYTE_W-1:0] OW_SKIP_ROM = 8'hCC;
	localparam logic [BYTE_W-1:0] OW_CONVERT  = 8'h44;
	localparam logic [BYTE_W-1:0] OW_READ_PAD = 8'hBE;

	// Scale from raw sensor counts to hundredths of a degree.
	localparam logic [TEMP_W-1:0] TEMP_SCALE = 16'd50;

	// Commands to the one-wire master.
	typedef enum logic [CMD_W-1:0] {
		CMD_NONE  = 2'd0,
		CMD_RESET = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	// Sequence steps, one-hot.
	typedef enum logic [8:0] {
		ST_IDLE      = 9'b000000001,
		ST_SKIP1     = 9'b000000010,
		ST_CONVERT   = 9'b000000100,
		ST_CONV_WAIT = 9'b000001000,
		ST_SKIP2     = 9'b000010000,
		ST_READ_PAD  = 9'b000100000,
		ST_READ_LO   = 9'b001000000,
		ST_TAKE_LO   = 9'b010000000,
		ST_TAKE_HI   = 9'b100000000
	} step_t;

	// Configuration registers as seen by the sequencer.
	typedef struct packed {
		logic [CFG_W-1:0] poll_period_ms;
		logic [CFG_W-1:0] conversion_wait_ms;
	} cfg_t;

	// One poll beat.
	typedef struct packed {
		logic              ms_tick;
		logic              bus_busy;
		logic [BYTE_W-1:0] read_data;
	} item_t;

	// One result beat.
	typedef struct packed {
		cmd_t                     bus_command;
		logic [BYTE_W-1:0]        write_data;
		logic signed [TEMP_W-1:0] temperature;
		logic                     temp_updated;
	} result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/otps_ifs.sv -----
// Valid/ready channel interfaces for the poll input and the result output.
// Depends on otps_pkg for field widths.
`default_nettype none

interface otps_poll_if;
	import otps_pkg::*;

	logic              valid;
	logic              ready;
	logic              ms_tick;
	logic              bus_busy;
	logic [BYTE_W-1:0] read_data;

	modport source (output valid, output ms_tick, output bus_busy, output read_data,
		input ready);
	modport sink (input valid, input ms_tick, input bus_busy, input read_data,
		output ready);
endinterface

interface otps_result_if;
	import otps_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         bus_command;
	logic [BYTE_W-1:0]        write_data;
	logic signed [TEMP_W-1:0] temperature;
	logic                     temp_updated;

	modport source (output valid, output bus_command, output write_data,
		output temperature, output temp_updated, input ready);
	modport sink (input valid, input bus_command, input write_data,
		input temperature, input temp_updated, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/otps_seq.sv -----
// Sequencer state and per-beat step logic: counters, step register, low byte, temperature.
// Depends on otps_pkg. State advances in every cycle in which step_en is high.
`default_nettype none

module otps_seq (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                step_en,
	input  otps_pkg::item_t    item,
	input  otps_pkg::cfg_t     cfg,
	output otps_pkg::result_t  res
);
	import otps_pkg::*;

	step_t              step_q, step_n;
	logic [COUNT_W-1:0] period_q, period_n, period_tick;
	logic [COUNT_W-1:0] wait_q, wait_n, wait_tick;
	logic [BYTE_W-1:0]  low_q, low_n;
	logic [TEMP_W-1:0]  temp_q, temp_n;
	logic [TEMP_W-1:0]  raw;
	logic [TEMP_W-1:0]  scaled;

	// Millisecond counters, saturating at all ones.
	assign period_tick = (item.ms_tick && (period_q != '1)) ? period_q + 1'b1 : period_q;
	assign wait_tick   = (item.ms_tick && (wait_q != '1)) ? wait_q + 1'b1 : wait_q;

	// Raw reading from the two scratchpad bytes, scaled to hundredths of a degree.
	assign raw    = {item.read_data, low_q};
	assign scaled = TEMP_W'(raw * TEMP_SCALE);

	// Restart check, then the current step.
	always_comb begin
		step_n           = step_q;
		period_n         = period_tick;
		wait_n           = wait_tick;
		low_n            = low_q;
		temp_n           = temp_q;
		res.bus_command  = CMD_NONE;
		res.write_data   = '0;
		res.temp_updated = 1'b0;

		if (period_tick >= cfg.poll_period_ms) begin
			period_n        = '0;
			step_n          = ST_SKIP1;
			res.bus_command = CMD_RESET;
		end else begin
			case (step_q)
				ST_IDLE: begin
				end
				ST_SKIP1, ST_SKIP2: begin
					if (!item.bus_busy) begin
						step_n          = (step_q == ST_SKIP1) ? ST_CONVERT : ST_READ_PAD;
						res.bus_command = CMD_WRITE;
						res.write_data  = OW_SKIP_ROM;
					end
				end
				ST_CONVERT: begin
					if (!item.bus_busy) begin
						step_n          = ST_CONV_WAIT;
						res.bus_command = CMD_WRITE;
						res.write_data  = OW_CONVERT;
						wait_n          = '0;
					end
				end
				ST_CONV_WAIT: begin
					// The conversion wait does not look at the busy flag.
					if (wait_tick >= cfg.conversion_wait_ms) begin
						wait_n          = '0;
						step_n          = ST_SKIP2;
						res.bus_command = CMD_RESET;
					end
				end
				ST_READ_PAD: begin
					if (!item.bus_busy) begin
						step_n          = ST_READ_LO;
						res.bus_command = CMD_WRITE;
						res.write_data  = OW_READ_PAD;
					end
				end
				ST_READ_LO: begin
					if (!item.bus_busy) begin
						step_n          = ST_TAKE_LO;
						res.bus_command = CMD_READ;
					end
				end
				ST_TAKE_LO: begin
					if (!item.bus_busy) begin
						low_n           = item.read_data;
						step_n          = ST_TAKE_HI;
						res.bus_command = CMD_READ;
					end
				end
				ST_TAKE_HI: begin
					if (!item.bus_busy) begin
						temp_n           = scaled;
						res.temp_updated = 1'b1;
						step_n           = ST_IDLE;
					end
				end
				default: begin
					step_n = ST_IDLE;
				end
			endcase
		end

		res.temperature = signed'(temp_n);
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= ST_IDLE;
			period_q <= '0;
			wait_q   <= '0;
			low_q    <= '0;
			temp_q   <= '0;
		end else if (step_en) begin
			step_q   <= step_n;
			period_q <= period_n;
			wait_q   <= wait_n;
			low_q    <= low_n;
			temp_q   <= temp_n;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/onewire_temp_poll_sequencer_core.sv -----
// Top level of the one-wire temperature poll sequencer.
// Depends on otps_pkg, otps_ifs (channel interfaces) and otps_seq.
//
// Usage:
//   poll_in carries one beat per poll of the one-wire master: ms_tick, bus_busy and the
//   last read byte. result_out returns exactly one beat per poll beat: the bus command
//   to issue, its write byte, the latest temperature in hundredths of a degree and a
//   flag that marks a freshly formed temperature.
//   cfg_we/cfg_index/cfg_wdata write the poll period (index 0) and the conversion wait
//   (index 1), both in milliseconds; write them only while no beat is in flight.
// Timing:
//   A poll beat is registered in the input register on acceptance, and its result is
//   registered in the result register when that register is empty or being drained.
//   One beat is taken per cycle while result_out.ready does not hold the result
//   register full.
// Reset:
//   arst_n clears both pipeline valids, the sequencer returns to idle with zeroed
//   counters and temperature, and the registers return to 3000 ms and 800 ms.
// Backpressure:
//   While a result beat waits on result_out.ready, the input register still accepts
//   one more beat; after that poll_in.ready drops until the result is taken.
`default_nettype none

module onewire_temp_poll_sequencer_core (
	input  wire                               clk,
	input  wire                               arst_n,
	otps_poll_if.sink                         poll_in,
	otps_result_if.source                     result_out,
	input  wire                               cfg_we,
	input  wire [otps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [otps_pkg::CFG_W-1:0]         cfg_wdata
);
	import otps_pkg::*;

	cfg_t    cfg_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    res_valid_q;
	result_t res_q;
	result_t res_n;
	logic    advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poll_period_ms     <= POLL_PERIOD_RST;
			cfg_q.conversion_wait_ms <= CONV_WAIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POLL_PERIOD: cfg_q.poll_period_ms     <= cfg_wdata;
				REG_CONV_WAIT:   cfg_q.conversion_wait_ms <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// The pipeline moves when the result register is empty or being drained.
	assign advance       = !res_valid_q || result_out.ready;
	assign poll_in.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll_in.ready) begin
			valid_s1 <= poll_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_in.valid && poll_in.ready) begin
			item_s1.ms_tick   <= poll_in.ms_tick;
			item_s1.bus_busy  <= poll_in.bus_busy;
			item_s1.read_data <= poll_in.read_data;
		end
	end

	// Step logic and sequencer state.
	otps_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (valid_s1 && advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.res     (res_n)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_q <= res_n;
		end
	end

	assign result_out.valid        = res_valid_q;
	assign result_out.bus_command  = res_q.bus_command;
	assign result_out.write_data   = res_q.write_data;
	assign result_out.temperature  = res_q.temperature;
	assign result_out.temp_updated = res_q.temp_updated;

endmodule

`default_nettype wire

// ----- hw/rtl/otps_checker.sv -----
// Port-level checker for the one-wire temperature poll sequencer, bound to the top level.
// Depends on otps_pkg for command and byte codes.
`default_nettype none

module otps_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             res_valid,
	input wire                             res_ready,
	input wire [otps_pkg::CMD_W-1:0]       bus_command,
	input wire [otps_pkg::BYTE_W-1:0]      write_data,
	input wire [otps_pkg::TEMP_W-1:0]      temperature,
	input wire                             temp_updated
);
	import otps_pkg::*;

	// A write byte appears only with a write command.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (bus_command != CMD_WRITE)) |-> (write_data == '0))
		else $error("write_data set without a write command");

	// A write command carries one of the three one-wire function bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (bus_command == CMD_WRITE)) |->
		((write_data == OW_SKIP_ROM) || (write_data == OW_CONVERT) ||
		 (write_data == OW_READ_PAD)))
		else $error("unexpected one-wire function byte");

	// The beat that forms a temperature issues no bus command.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && temp_updated) |-> (bus_command == CMD_NONE))
		else $error("bus command issued with a temperature update");

	// A stalled result beat holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=>
		(res_valid && $stable(bus_command) && $stable(write_data) &&
		 $stable(temperature) && $stable(temp_updated)))
		else $error("stalled result beat changed");

endmodule

bind onewire_temp_poll_sequencer_core otps_checker u_otps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result_out.valid),
	.res_ready    (result_out.ready),
	.bus_command  (result_out.bus_command),
	.write_data   (result_out.write_data),
	.temperature  (result_out.temperature),
	.temp_updated (result_out.temp_updated)
);

`default_nettype wire
